@@ design/stack_machine_data_stack_alu_top_macros.svh @@
// ----------------------------------------------------------------------------
// Stack machine data stack assertion macros
// Shared property forms for the data stack checks.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_DATA_STACK_ALU_TOP_MACROS_SVH
`define STACK_MACHINE_DATA_STACK_ALU_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SM_DSTK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SM_DSTK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sm_dstk_pkg.sv @@
// ----------------------------------------------------------------------------
// Stack machine data stack package
// Field widths, operation codes and sequencer states shared by the design.
// ----------------------------------------------------------------------------
package sm_dstk_pkg;

  localparam int OP_BITS    = 4;
  localparam int WORD_BITS  = 64;
  localparam int DEPTH_BITS = 5;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_DUP  = 4'd5,
    OP_SWAP = 4'd6,
    OP_DROP = 4'd7,
    OP_POP  = 4'd8
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_POP1,
    S_POP2,
    S_CALC,
    S_ITER,
    S_FIN,
    S_CAP,
    S_SWAP1,
    S_SWAP2,
    S_SWAP3,
    S_SWAP4,
    S_TOP,
    S_DONE
  } state_t;

endpackage

@@ design/sm_dstk_if.sv @@
// ----------------------------------------------------------------------------
// Stack machine data stack channels
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface sm_dstk_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic [sm_dstk_pkg::OP_BITS-1:0]        op;
  logic signed [sm_dstk_pkg::WORD_BITS-1:0] literal;

  modport source (output valid, output op, output literal, input ready);
  modport sink   (input valid, input op, input literal, output ready);
endinterface

interface sm_dstk_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [sm_dstk_pkg::WORD_BITS-1:0] value;
  logic [sm_dstk_pkg::DEPTH_BITS-1:0]       depth;
  logic                                     underflow;
  logic                                     overflow;
  logic                                     divide_by_zero;

  modport source (output valid, output value, output depth, output underflow,
                  output overflow, output divide_by_zero, input ready);
  modport sink   (input valid, input value, input depth, input underflow,
                  input overflow, input divide_by_zero, output ready);
endinterface

@@ design/stack_machine_data_stack_alu_top.sv @@
// ----------------------------------------------------------------------------
// Stack machine data stack with arithmetic
// Bounded stack of signed cells in a synchronous memory, driven by a
// sequencer that pops, computes and pushes one operation item at a time.
// ----------------------------------------------------------------------------
// Usage: each item on the cmd channel is one operation (push literal, add,
// sub, mul, div, dup, swap, drop, pop) and produces exactly one item on the
// rsp channel carrying the new top of stack (or the removed entry for drop
// and pop), the depth afterwards and the underflow, overflow and divide by
// zero flags. Both channels use valid/ready; an item moves when both are high.
// A new item is accepted only once the previous one has reached the result
// register, so the sequencer works on one item at a time. Its pace is set
// by the single read port and single write port of the stack memory, which
// every operand pop, push and final top-of-stack read goes through one at
// a time, and by the bit-serial shift-add multiply and restoring divide loop,
// which retires one bit per cycle. Division by zero skips the loop, and swap
// on fewer than two entries and the unused codes go straight to the final
// top-of-stack read.
// Reset empties the stack at once (the count clears; memory contents are not
// touched). While the receiver holds ready low the finished result stays in
// the output register; the next item is still accepted and worked on and
// waits at the end of its sequence until the register frees up.
// ----------------------------------------------------------------------------
`include "stack_machine_data_stack_alu_top_macros.svh"

module stack_machine_data_stack_alu_top #(
  parameter int STACK_DEPTH = 16,
  parameter int CELL_BITS   = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  sm_dstk_cmd_if.sink          cmd,
  sm_dstk_rsp_if.source        rsp
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (CELL_BITS > 1) ? $clog2(CELL_BITS) : 1;
  localparam int N  = CELL_BITS;
  localparam int WB = sm_dstk_pkg::WORD_BITS;
  localparam int DB = sm_dstk_pkg::DEPTH_BITS;

  // Control registers.
  sm_dstk_pkg::state_t state, state_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic                out_valid, out_valid_next;

  // Working registers.
  logic [sm_dstk_pkg::OP_BITS-1:0] op_q, op_q_next;
  logic [N-1:0]  res, res_next;
  logic [N-1:0]  b_op, b_op_next;
  logic [N-1:0]  x, x_next;
  logic [N-1:0]  y, y_next;
  logic [N-1:0]  acc, acc_next;
  logic [IW-1:0] iter, iter_next;
  logic          neg, neg_next;
  logic          hit, hit_next;
  logic          again, again_next;
  logic          under, under_next;
  logic          over, over_next;
  logic          dz, dz_next;

  // Result register.
  logic [WB-1:0] out_value, out_value_next;
  logic [DB-1:0] out_depth, out_depth_next;
  logic          out_under, out_under_next;
  logic          out_over, out_over_next;
  logic          out_dz, out_dz_next;

  // Stack memory, one write and one registered read per cycle.
  logic [N-1:0]  mem [STACK_DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [N-1:0]  wr_data, rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Helpers.
  logic          cnt_zero, full;
  logic [AW-1:0] top_addr, second_addr, push_addr;
  logic [N-1:0]  opnd, a_abs, b_abs;
  logic [N:0]    div_sh, div_diff;

  assign cnt_zero    = (cnt == '0);
  assign full        = (cnt == CW'(STACK_DEPTH));
  assign top_addr    = AW'(cnt - CW'(1));
  assign second_addr = AW'(cnt - CW'(2));
  assign push_addr   = AW'(cnt);
  assign opnd        = hit ? rd_data : '0;
  assign a_abs       = opnd[N-1] ? (~opnd + N'(1)) : opnd;
  assign b_abs       = b_op[N-1] ? (~b_op + N'(1)) : b_op;
  assign div_sh      = {acc, x[N-1]};
  assign div_diff    = div_sh - {1'b0, y};

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid;
    op_q_next      = op_q;
    res_next       = res;
    b_op_next      = b_op;
    x_next         = x;
    y_next         = y;
    acc_next       = acc;
    iter_next      = iter;
    neg_next       = neg;
    hit_next       = hit;
    again_next     = again;
    under_next     = under;
    over_next      = over;
    dz_next        = dz;
    out_value_next = out_value;
    out_depth_next = out_depth;
    out_under_next = out_under;
    out_over_next  = out_over;
    out_dz_next    = out_dz;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    wr_addr        = push_addr;
    rd_addr        = top_addr;
    wr_data        = res;
    cmd.ready      = 1'b0;

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      sm_dstk_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          op_q_next  = cmd.op;
          res_next   = cmd.literal[N-1:0];
          under_next = 1'b0;
          over_next  = 1'b0;
          dz_next    = 1'b0;
          again_next = (cmd.op == sm_dstk_pkg::OP_DUP);
          case (cmd.op) inside
            sm_dstk_pkg::OP_PUSH: begin
              state_next = sm_dstk_pkg::S_PUSH;
            end
            sm_dstk_pkg::OP_ADD, sm_dstk_pkg::OP_SUB, sm_dstk_pkg::OP_MUL,
            sm_dstk_pkg::OP_DIV, sm_dstk_pkg::OP_DUP, sm_dstk_pkg::OP_DROP,
            sm_dstk_pkg::OP_POP: begin
              state_next = sm_dstk_pkg::S_POP1;
            end
            sm_dstk_pkg::OP_SWAP: begin
              if (cnt < CW'(2)) begin
                under_next = 1'b1;
                state_next = sm_dstk_pkg::S_TOP;
              end else begin
                state_next = sm_dstk_pkg::S_SWAP1;
              end
            end
            default: begin
              state_next = sm_dstk_pkg::S_TOP;
            end
          endcase
        end
      end

      sm_dstk_pkg::S_PUSH: begin
        if (full) begin
          over_next = 1'b1;
        end else begin
          mem_we   = 1'b1;
          cnt_next = cnt + CW'(1);
        end
        if (again) begin
          again_next = 1'b0;
        end else begin
          state_next = sm_dstk_pkg::S_TOP;
        end
      end

      sm_dstk_pkg::S_POP1: begin
        if (cnt_zero) begin
          under_next = 1'b1;
          hit_next   = 1'b0;
        end else begin
          mem_re   = 1'b1;
          cnt_next = cnt - CW'(1);
          hit_next = 1'b1;
        end
        case (op_q) inside
          sm_dstk_pkg::OP_ADD, sm_dstk_pkg::OP_SUB, sm_dstk_pkg::OP_MUL,
          sm_dstk_pkg::OP_DIV: begin
            state_next = sm_dstk_pkg::S_POP2;
          end
          sm_dstk_pkg::OP_DUP: begin
            state_next = sm_dstk_pkg::S_CAP;
          end
          default: begin
            state_next = sm_dstk_pkg::S_DONE;
          end
        endcase
      end

      sm_dstk_pkg::S_POP2: begin
        b_op_next = opnd;
        if (cnt_zero) begin
          under_next = 1'b1;
          hit_next   = 1'b0;
        end else begin
          mem_re   = 1'b1;
          cnt_next = cnt - CW'(1);
          hit_next = 1'b1;
        end
        state_next = sm_dstk_pkg::S_CALC;
      end

      sm_dstk_pkg::S_CALC: begin
        iter_next  = '0;
        acc_next   = '0;
        state_next = sm_dstk_pkg::S_PUSH;
        case (op_q)
          sm_dstk_pkg::OP_ADD: res_next = opnd + b_op;
          sm_dstk_pkg::OP_SUB: res_next = opnd - b_op;
          sm_dstk_pkg::OP_MUL: begin
            x_next     = opnd;
            y_next     = b_op;
            state_next = sm_dstk_pkg::S_ITER;
          end
          sm_dstk_pkg::OP_DIV: begin
            if (b_op == '0) begin
              res_next = '0;
              dz_next  = 1'b1;
            end else begin
              x_next     = a_abs;
              y_next     = b_abs;
              neg_next   = opnd[N-1] ^ b_op[N-1];
              state_next = sm_dstk_pkg::S_ITER;
            end
          end
          default: res_next = '0;
        endcase
      end

      // One bit of the product or quotient per cycle.
      sm_dstk_pkg::S_ITER: begin
        if (op_q == sm_dstk_pkg::OP_MUL) begin
          if (y[0]) begin
            acc_next = acc + x;
          end
          x_next = x << 1;
          y_next = y >> 1;
        end else begin
          if (!div_diff[N]) begin
            acc_next = div_diff[N-1:0];
            x_next   = {x[N-2:0], 1'b1};
          end else begin
            acc_next = div_sh[N-1:0];
            x_next   = {x[N-2:0], 1'b0};
          end
        end
        iter_next = iter + IW'(1);
        if (iter == IW'(N - 1)) begin
          state_next = sm_dstk_pkg::S_FIN;
        end
      end

      sm_dstk_pkg::S_FIN: begin
        if (op_q == sm_dstk_pkg::OP_MUL) begin
          res_next = acc;
        end else begin
          res_next = neg ? (~x + N'(1)) : x;
        end
        state_next = sm_dstk_pkg::S_PUSH;
      end

      sm_dstk_pkg::S_CAP: begin
        res_next   = opnd;
        state_next = sm_dstk_pkg::S_PUSH;
      end

      sm_dstk_pkg::S_SWAP1: begin
        mem_re     = 1'b1;
        rd_addr    = top_addr;
        state_next = sm_dstk_pkg::S_SWAP2;
      end

      sm_dstk_pkg::S_SWAP2: begin
        b_op_next  = rd_data;
        mem_re     = 1'b1;
        rd_addr    = second_addr;
        state_next = sm_dstk_pkg::S_SWAP3;
      end

      sm_dstk_pkg::S_SWAP3: begin
        mem_we     = 1'b1;
        wr_addr    = top_addr;
        wr_data    = rd_data;
        state_next = sm_dstk_pkg::S_SWAP4;
      end

      sm_dstk_pkg::S_SWAP4: begin
        mem_we     = 1'b1;
        wr_addr    = second_addr;
        wr_data    = b_op;
        state_next = sm_dstk_pkg::S_TOP;
      end

      sm_dstk_pkg::S_TOP: begin
        hit_next = !cnt_zero;
        mem_re   = !cnt_zero;
        rd_addr  = top_addr;
        state_next = sm_dstk_pkg::S_DONE;
      end

      sm_dstk_pkg::S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_value_next = WB'($signed(opnd));
          out_depth_next = DB'(cnt);
          out_under_next = under;
          out_over_next  = over;
          out_dz_next    = dz;
          state_next     = sm_dstk_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = sm_dstk_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sm_dstk_pkg::S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q      <= op_q_next;
    res       <= res_next;
    b_op      <= b_op_next;
    x         <= x_next;
    y         <= y_next;
    acc       <= acc_next;
    iter      <= iter_next;
    neg       <= neg_next;
    hit       <= hit_next;
    again     <= again_next;
    under     <= under_next;
    over      <= over_next;
    dz        <= dz_next;
    out_value <= out_value_next;
    out_depth <= out_depth_next;
    out_under <= out_under_next;
    out_over  <= out_over_next;
    out_dz    <= out_dz_next;
  end

  assign rsp.valid          = out_valid;
  assign rsp.value          = out_value;
  assign rsp.depth          = out_depth;
  assign rsp.underflow      = out_under;
  assign rsp.overflow       = out_over;
  assign rsp.divide_by_zero = out_dz;

  // Checks.
  `SM_DSTK_ASSERT_NOW(a_cnt_bound, clk, rst, 1'b1, cnt <= CW'(STACK_DEPTH), "stack count beyond depth")
  `SM_DSTK_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd.valid && cmd.ready, state != sm_dstk_pkg::S_IDLE, "sequencer idle after accepting an item")
  `SM_DSTK_ASSERT_NOW(a_dz_zero, clk, rst, out_valid && out_dz, out_value == '0, "divide by zero result is not zero")
  `SM_DSTK_ASSERT_NOW(a_over_full, clk, rst, out_valid && out_over, out_depth == DB'(STACK_DEPTH), "overflow reported below full depth")

endmodule

@@ test/stack_outcome_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Data stack outcome checker
// Replays every accepted operation item on a private copy of the stack and
// compares each result item, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module stack_outcome_checker
  import sm_dstk_pkg::*;
#(
  parameter int STACK_CELLS = 16
) (
  input  logic   clk,
  input  logic   rst,
  sm_dstk_cmd_if cmd,
  sm_dstk_rsp_if rsp,
  output int     failures,
  output int     in_flight
);

  typedef struct {
    op_t                   op;
    logic [WORD_BITS-1:0]  value;
    logic [DEPTH_BITS-1:0] depth;
    logic                  underflow;
    logic                  overflow;
    logic                  divide_by_zero;
  } stack_outcome_t;

  logic [WORD_BITS-1:0] cells [STACK_CELLS];
  int                   live;
  logic                 saw_empty;
  logic                 saw_full;
  stack_outcome_t       outcomes_due [$];

  function automatic void put_cell(logic [WORD_BITS-1:0] v);
    if (live >= STACK_CELLS) begin
      saw_full = 1'b1;
    end else begin
      cells[live] = v;
      live++;
    end
  endfunction

  function automatic logic [WORD_BITS-1:0] take_cell();
    if (live == 0) begin
      saw_empty = 1'b1;
      return '0;
    end
    live--;
    return cells[live];
  endfunction

  // Executes one operation on the shadow stack and returns the result item
  // that the block must produce for it.
  function automatic stack_outcome_t execute_op(op_t op, logic [WORD_BITS-1:0] lit);
    stack_outcome_t       r;
    logic [WORD_BITS-1:0] a, b, v, mag_a, mag_b, q;
    logic                 removed;
    saw_empty = 1'b0;
    saw_full  = 1'b0;
    removed   = 1'b0;
    v         = '0;
    r.op             = op;
    r.divide_by_zero = 1'b0;
    case (op)
      OP_PUSH: put_cell(lit);
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        b = take_cell();
        a = take_cell();
        case (op)
          OP_ADD: v = a + b;
          OP_SUB: v = a - b;
          OP_MUL: v = a * b;
          default: begin
            if (b == '0) begin
              r.divide_by_zero = 1'b1;
            end else begin
              // Divide magnitudes, then fix the sign so the quotient
              // truncates toward zero; the most negative value over minus
              // one wraps back to itself.
              mag_a = a[WORD_BITS-1] ? -a : a;
              mag_b = b[WORD_BITS-1] ? -b : b;
              q     = mag_a / mag_b;
              v     = (a[WORD_BITS-1] ^ b[WORD_BITS-1]) ? -q : q;
            end
          end
        endcase
        put_cell(v);
      end
      OP_DUP: begin
        a = take_cell();
        put_cell(a);
        put_cell(a);
      end
      OP_SWAP: begin
        if (live < 2) begin
          saw_empty = 1'b1;
        end else begin
          a               = cells[live - 1];
          cells[live - 1] = cells[live - 2];
          cells[live - 2] = a;
        end
      end
      OP_DROP, OP_POP: begin
        v       = take_cell();
        removed = 1'b1;
      end
      default: ;
    endcase
    if (!removed) v = (live > 0) ? cells[live - 1] : '0;
    r.value     = v;
    r.depth     = DEPTH_BITS'(live);
    r.underflow = saw_empty;
    r.overflow  = saw_full;
    return r;
  endfunction

  function automatic void note_failure(string what);
    failures++;
    if (failures <= 10) $display("%0t ns: %s", $time, what);
  endfunction

  always @(posedge clk) begin
    stack_outcome_t want;
    if (rst) begin
      live = 0;
      outcomes_due.delete();
    end else begin
      // Results are handled first: a result never belongs to the item that
      // is accepted at the same edge.
      if (rsp.valid && rsp.ready) begin
        if (outcomes_due.size() == 0) begin
          note_failure($sformatf("unexpected result: value %0d depth %0d",
                                 $signed(rsp.value), rsp.depth));
        end else begin
          want = outcomes_due.pop_front();
          if (rsp.value !== want.value || rsp.depth !== want.depth ||
              rsp.underflow !== want.underflow || rsp.overflow !== want.overflow ||
              rsp.divide_by_zero !== want.divide_by_zero) begin
            note_failure($sformatf({"%s mismatch: expected value %0d depth %0d ",
                                    "uf %b ovf %b dz %b, got value %0d depth %0d ",
                                    "uf %b ovf %b dz %b"},
                                   want.op.name(), $signed(want.value), want.depth,
                                   want.underflow, want.overflow, want.divide_by_zero,
                                   $signed(rsp.value), rsp.depth, rsp.underflow,
                                   rsp.overflow, rsp.divide_by_zero));
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        outcomes_due.push_back(execute_op(op_t'(cmd.op), cmd.literal));
      end
    end
    in_flight = outcomes_due.size();
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Data stack with arithmetic, block-level test
// Drives operation items into the stack block with random pacing on both
// channels; a separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;
  import sm_dstk_pkg::*;

  // The block's own sizes; the checker uses the same depth.
  localparam int STACK_CELLS = 16;
  localparam int CELL_WIDTH  = 64;

  // Random items after the directed opening; the last CALM_ITEMS of them run
  // with no idling on either side.
  localparam int RANDOM_ITEMS = 1325;
  localparam int CALM_ITEMS   = 150;

  // The settle wait at the end covers a multiply or divide, the slowest
  // operations, once more. The watchdog allows many times the longest
  // correct stretch without a handshake (sender gap, slowest operation and
  // receiver stall back to back).
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT   = 1500;

  localparam logic [WORD_BITS-1:0] CELL_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] CELL_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] CELL_ONE = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] CELL_NEG = {WORD_BITS{1'b1}};

  // Bias of a run of random items: grow the stack toward full, shrink it
  // toward empty, or churn around the current depth.
  typedef enum logic [1:0] {GROW, SHRINK, CHURN} stack_trend_t;

  logic clk;
  logic rst;
  logic calm;
  int   gap_odds;
  int   failures;
  int   in_flight;
  int   quiet_cycles;

  sm_dstk_cmd_if cmd_ch ();
  sm_dstk_rsp_if rsp_ch ();

  stack_machine_data_stack_alu_top #(
    .STACK_DEPTH (STACK_CELLS),
    .CELL_BITS   (CELL_WIDTH)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  stack_outcome_checker #(
    .STACK_CELLS (STACK_CELLS)
  ) outcome_check (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .failures  (failures),
    .in_flight (in_flight)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Every input is driven at the falling edge, so the block and the checker
  // see stable values at the rising edge. An item is offered once with valid
  // high and held until the edge at which ready is seen high. When the
  // sender is in an idling phase, a burst of empty cycles may come first.
  task automatic issue(op_t o, logic [WORD_BITS-1:0] lit);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds * 3) == 1) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.op      <= o;
    cmd_ch.literal <= lit;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds the sender off until every result item has come back. At least
  // one falling edge passes with valid low, so valid never drops and rises
  // again in the same step.
  task automatic drain_all();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (in_flight != 0);
  endtask

  // Literals mix full-width random patterns with small values, which make
  // divisions, zero divisors and carries likely, and with the extremes.
  function automatic logic [WORD_BITS-1:0] pick_literal();
    logic [WORD_BITS-1:0] raw;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: raw = {$urandom, $urandom};
      4, 5, 6:    raw = WORD_BITS'(longint'($urandom_range(0, 40)) - 20);
      7:          raw = CELL_MIN;
      8:          raw = CELL_MAX;
      default:    raw = WORD_BITS'(longint'($urandom_range(0, 2)) - 1);
    endcase
    return raw;
  endfunction

  function automatic op_t pick_op(stack_trend_t trend);
    int roll;
    roll = $urandom_range(0, 99);
    case (trend)
      GROW: begin
        if (roll < 80) return OP_PUSH;
        if (roll < 90) return OP_DUP;
      end
      SHRINK: begin
        if (roll < 30) return OP_POP;
        if (roll < 60) return OP_DROP;
        if (roll < 90) return op_t'($urandom_range(OP_ADD, OP_DIV));
      end
      default: begin
        if (roll < 30) return OP_PUSH;
      end
    endcase
    return op_t'($urandom_range(OP_ADD, OP_POP));
  endfunction

  // Watchdog: a run of cycles with no handshake on either channel means the
  // block has hung or lost an item.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[stack_machine_data_stack_alu_top] ERROR");
        $finish;
      end
    end
  end

  // The receiver alternates phases: some with no stalls at all, others with
  // stall bursts at varying density. The final calm part
  // keeps ready high throughout.
  initial begin : result_pacing
    int phase_left;
    int stall_odds;
    phase_left   = 0;
    stall_odds   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        phase_left = $urandom_range(30, 300);
        stall_odds = $urandom_range(0, 4);
      end
      phase_left--;
      if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds * 3) == 1) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin : stimulus
    stack_trend_t trend;
    int           run_len;
    int           sent;
    calm           = 1'b0;
    gap_odds       = 2;
    rst            = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.op      = OP_PUSH;
    cmd_ch.literal = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening. Every read of an empty stack comes first: pop and
    // drop on nothing, a binary operation with both operands missing, swap
    // on a single entry, arithmetic with one operand missing, a divide that
    // lacks its dividend and has a zero divisor, and dup on an empty stack.
    issue(OP_POP, '0);
    issue(OP_DROP, '0);
    issue(OP_ADD, '0);
    issue(OP_SWAP, '0);
    issue(OP_SUB, '0);
    issue(OP_DUP, '0);
    issue(OP_MUL, '0);
    issue(OP_DIV, '0);
    issue(OP_POP, '0);
    issue(OP_SWAP, '0);
    issue(OP_DUP, '0);
    issue(OP_POP, '0);
    issue(OP_DROP, '0);
    // The most negative value over minus one wraps to itself, and adding
    // the largest value to it gives minus one.
    issue(OP_PUSH, CELL_MIN);
    issue(OP_PUSH, CELL_NEG);
    issue(OP_DIV, '0);
    issue(OP_PUSH, CELL_MAX);
    issue(OP_ADD, '0);
    // Swap with two entries, then operand order for subtract and a divide
    // whose quotient truncates toward zero with mixed signs.
    issue(OP_PUSH, WORD_BITS'(7));
    issue(OP_SWAP, '0);
    issue(OP_SUB, '0);
    issue(OP_PUSH, WORD_BITS'(-7));
    issue(OP_DIV, '0);
    issue(OP_PUSH, CELL_ONE);
    // A zero divisor yields zero with its own flag.
    issue(OP_PUSH, '0);
    issue(OP_DIV, '0);

    // The sender waits for every result here, and four more times below.
    drain_all();

    // Random part in runs of a few to a few dozen items. Growing runs reach
    // the full stack, where pushes and the second half of a dup are
    // dropped; shrinking runs empty it again. Each run picks its own sender
    // idling density, none for some runs.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      trend    = stack_trend_t'($urandom_range(GROW, CHURN));
      run_len  = $urandom_range(6, 30);
      gap_odds = $urandom_range(0, 4);
      for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
        if (sent == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
        if (sent % 400 == 200) drain_all();
        issue(pick_op(trend), pick_literal());
        sent++;
      end
    end

    // All items are in; wait for the last results, then long enough for a
    // stray extra result to show up before the verdict.
    drain_all();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("[stack_machine_data_stack_alu_top] OK");
    end else begin
      $display("[stack_machine_data_stack_alu_top] ERROR");
    end
    $finish;
  end

endmodule
